[hw/rtl/csv_field_splitter_core_assert.svh]
// Assertion macros for the CSV field splitter.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef CSV_FIELD_SPLITTER_CORE_ASSERT_SVH
`define CSV_FIELD_SPLITTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSVFS_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csvfs assertion failed");

// The expression must never be true.
`define CSVFS_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("csvfs assertion failed");

`endif

[hw/rtl/csvfs_pkg.sv]
// Shared types and constants of the CSV field splitter.
// No dependencies; used by every module of the block.
`default_nettype none

package csvfs_pkg;

  localparam int SPACE_BUFFER_DEPTH = 16;
  localparam int SPACE_CNT_W = $clog2(SPACE_BUFFER_DEPTH + 1);
  localparam int SPACE_IDX_W = (SPACE_BUFFER_DEPTH > 1) ? $clog2(SPACE_BUFFER_DEPTH) : 1;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;

  typedef enum logic [2:0] {
    PH_START,
    PH_LEAD,
    PH_UNQ,
    PH_QUOTED,
    PH_QSEEN,
    PH_AFTERQ,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    OP_EMIT,
    OP_SPACE,
    OP_FLUSH,
    OP_FEND,
    OP_TERM
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       owed;
  } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/csvfs_front.sv]
// Front end: accepts input words, tracks the parse phase and turns each word
// into at most one command for the back end. Depends on csvfs_pkg.
`default_nettype none

module csvfs_front
  import csvfs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       in_terminator,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  phase_t phase_r, phase_nxt;
  logic   any_field_r, any_field_nxt;
  logic   last_comma_r, last_comma_nxt;
  logic   accept;
  logic   is_ws;
  logic   is_eol;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_ws    = (in_char_byte == CH_SPACE) || (in_char_byte == CH_TAB) ||
                    (in_char_byte == CH_VT) || (in_char_byte == CH_FF);
  assign is_eol   = (in_char_byte == CH_LF) || (in_char_byte == CH_CR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      any_field_r  <= 1'b0;
      last_comma_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      any_field_r  <= any_field_nxt;
      last_comma_r <= last_comma_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    any_field_nxt  = any_field_r;
    last_comma_nxt = last_comma_r;
    q_push         = 1'b0;
    q_cmd.op       = OP_EMIT;
    q_cmd.data     = in_char_byte;
    q_cmd.owed     = any_field_r || last_comma_r;
    if (accept) begin
      if (in_terminator) begin
        q_push         = 1'b1;
        q_cmd.op       = OP_TERM;
        phase_nxt      = PH_START;
        any_field_nxt  = 1'b0;
        last_comma_nxt = 1'b0;
      end else begin
        unique case (phase_r)
          PH_QSEEN: begin
            if (in_char_byte == CH_QUOTE) begin
              // A doubled quote inside quotes stands for one quote.
              q_push    = 1'b1;
              q_cmd.op  = OP_EMIT;
              phase_nxt = PH_QUOTED;
            end else if (in_char_byte == CH_COMMA) begin
              q_push         = 1'b1;
              q_cmd.op       = OP_FEND;
              phase_nxt      = PH_START;
              last_comma_nxt = 1'b1;
            end else if (is_eol) begin
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_AFTERQ;
            end
          end
          PH_QUOTED: begin
            if (in_char_byte == CH_QUOTE) begin
              phase_nxt = PH_QSEEN;
            end else begin
              q_push   = 1'b1;
              q_cmd.op = OP_EMIT;
            end
          end
          PH_AFTERQ: begin
            if (in_char_byte == CH_COMMA) begin
              q_push         = 1'b1;
              q_cmd.op       = OP_FEND;
              phase_nxt      = PH_START;
              last_comma_nxt = 1'b1;
            end else if (is_eol) begin
              phase_nxt = PH_DONE;
            end
          end
          PH_START, PH_LEAD, PH_UNQ: begin
            if (is_eol) begin
              // Held whitespace is discarded by the terminator command.
              phase_nxt = PH_DONE;
            end else if (in_char_byte == CH_COMMA) begin
              q_push         = 1'b1;
              q_cmd.op       = OP_FEND;
              phase_nxt      = PH_START;
              any_field_nxt  = 1'b1;
              last_comma_nxt = 1'b1;
            end else begin
              any_field_nxt  = 1'b1;
              last_comma_nxt = 1'b0;
              if (phase_r == PH_START && in_char_byte == CH_QUOTE) begin
                phase_nxt = PH_QUOTED;
              end else if (is_ws) begin
                if (phase_r == PH_UNQ) begin
                  q_push   = 1'b1;
                  q_cmd.op = OP_SPACE;
                end else begin
                  phase_nxt = PH_LEAD;
                end
              end else begin
                q_push    = 1'b1;
                q_cmd.op  = OP_FLUSH;
                phase_nxt = PH_UNQ;
              end
            end
          end
          PH_DONE: begin
            phase_nxt = PH_DONE;
          end
          default: begin
            phase_nxt = PH_START;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/csvfs_cmdq.sv]
// Command queue between front and back end: a small register FIFO.
// Depends on csvfs_pkg for the command type and depth.
`default_nettype none

module csvfs_cmdq
  import csvfs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output cmd_t      head
);

  cmd_t                  entry_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CMDQ_CNT_W'(do_push) - CMDQ_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/csvfs_back.sv]
// Back end: runs queued commands, holds the pending whitespace and drives
// the output register. Depends on csvfs_pkg.
`default_nettype none

module csvfs_back
  import csvfs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_empty,
  input  wire cmd_t       q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_out_byte,
  output logic            out_byte_valid,
  output logic            out_field_end,
  output logic            out_line_end,
  output logic            out_space_overflow
);

  logic [7:0]             space_r [SPACE_BUFFER_DEPTH];
  logic [SPACE_CNT_W-1:0] count_r, count_nxt;
  logic [SPACE_CNT_W-1:0] idx_r, idx_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   space_wr;
  logic                   load_ok;
  logic                   load;

  logic                   valid_r;
  logic [7:0]             byte_r, byte_nxt;
  logic                   bv_r, bv_nxt;
  logic                   fe_r, fe_nxt;
  logic                   le_r, le_nxt;
  logic                   ov_r, ov_nxt;

  assign load_ok = !valid_r || !out_stall;

  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    ovf_nxt   = ovf_r;
    space_wr  = 1'b0;
    load      = 1'b0;
    q_pop     = 1'b0;
    byte_nxt  = 8'h00;
    bv_nxt    = 1'b0;
    fe_nxt    = 1'b0;
    le_nxt    = 1'b0;
    ov_nxt    = 1'b0;
    if (!q_empty) begin
      unique case (q_head.op)
        OP_SPACE: begin
          q_pop = 1'b1;
          if (count_r < SPACE_CNT_W'(SPACE_BUFFER_DEPTH)) begin
            space_wr  = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        OP_EMIT: begin
          if (load_ok) begin
            load     = 1'b1;
            q_pop    = 1'b1;
            byte_nxt = q_head.data;
            bv_nxt   = 1'b1;
          end
        end
        OP_FLUSH: begin
          // Held whitespace goes out one word a cycle while the output is not stalled, then the content byte.
          if (load_ok) begin
            load   = 1'b1;
            bv_nxt = 1'b1;
            ov_nxt = ovf_r;
            if (idx_r < count_r) begin
              byte_nxt = space_r[idx_r[SPACE_IDX_W-1:0]];
              idx_nxt  = idx_r + 1'b1;
            end else begin
              byte_nxt  = q_head.data;
              q_pop     = 1'b1;
              idx_nxt   = '0;
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
          end
        end
        OP_FEND: begin
          if (load_ok) begin
            load      = 1'b1;
            q_pop     = 1'b1;
            fe_nxt    = 1'b1;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end
        end
        OP_TERM: begin
          if (load_ok) begin
            load      = 1'b1;
            q_pop     = 1'b1;
            fe_nxt    = q_head.owed;
            le_nxt    = 1'b1;
            count_nxt = '0;
            idx_nxt   = '0;
            ovf_nxt   = 1'b0;
          end
        end
        default: begin
          q_pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      ovf_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      ovf_r   <= ovf_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (space_wr) begin
      space_r[count_r[SPACE_IDX_W-1:0]] <= q_head.data;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      bv_r   <= bv_nxt;
      fe_r   <= fe_nxt;
      le_r   <= le_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_out_byte       = byte_r;
  assign out_byte_valid     = bv_r;
  assign out_field_end      = fe_r;
  assign out_line_end       = le_r;
  assign out_space_overflow = ov_r;

endmodule

`default_nettype wire

[hw/rtl/csv_field_splitter_core.sv]
// Top level of the CSV field splitter: front end, command queue, back end.
// Depends on csvfs_pkg, csvfs_front, csvfs_cmdq, csvfs_back and the assert header.
`default_nettype none
`include "csv_field_splitter_core_assert.svh"

// Splits one CSV line, given one byte per input word and closed by a
// terminator word, into content bytes with field-end and line-end marks.
// The front end takes one input word per cycle while the four-entry command
// queue has room. The back end delivers one result word per cycle while the
// output is not stalled; a content byte that follows held trailing spaces
// goes out after them, since the held spaces leave the space buffer one per
// cycle, so each such flush lowers the sustained rate of input words. Up to
// SPACE_BUFFER_DEPTH spaces are held; further ones are dropped and flagged.
// Output is registered; a result can wait under stall while input continues.
module csv_field_splitter_core
  import csvfs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       in_terminator,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_out_byte,
  output logic            out_byte_valid,
  output logic            out_field_end,
  output logic            out_line_end,
  output logic            out_space_overflow
);

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_empty;
  cmd_t q_head;

  csvfs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_byte  (in_char_byte),
    .in_terminator (in_terminator),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  csvfs_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  csvfs_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_out_byte       (out_out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_field_end      (out_field_end),
    .out_line_end       (out_line_end),
    .out_space_overflow (out_space_overflow)
  );

  // A content byte never closes a field or a line.
  `CSVFS_ASSERT_IMPLIES(a_byte_no_marks, out_valid && out_byte_valid,
                        !out_field_end && !out_line_end)
  // The overflow flag only rides on flushed content bytes.
  `CSVFS_ASSERT_IMPLIES(a_ovf_on_byte, out_valid && out_space_overflow, out_byte_valid)
  // Mark-only words carry a zero byte.
  `CSVFS_ASSERT_NEVER(a_mark_zero_byte, out_valid && !out_byte_valid && (out_out_byte != 8'h00))

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for csv_field_splitter_core: directed and random CSV lines,
// with results predicted and checked word by word by a small scoreboard class.
// Depends on csvfs_pkg and the csv_field_splitter_core RTL.
module tb;
  import csvfs_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_WORDS = 320;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       field_end;
    logic       line_end;
    logic       overflow;
  } piece_t;

  class field_split_checker;
    piece_t      expected_pieces[$];
    int unsigned fail_count;
    phase_t      phase;
    logic [7:0]  held_spaces[SPACE_BUFFER_DEPTH];
    int unsigned held_count;
    bit          spaces_dropped;
    bit          field_opened;
    bit          after_comma;

    function new();
      fail_count = 0;
      clear_line();
    endfunction

    function void clear_line();
      phase = PH_START;
      held_count = 0;
      spaces_dropped = 0;
      field_opened = 0;
      after_comma = 0;
    endfunction

    function void push(logic [7:0] d, bit dv, bit fe, bit le, bit ov);
      piece_t p;
      p.data = dv ? d : 8'h00;
      p.data_valid = dv;
      p.field_end = fe;
      p.line_end = le;
      p.overflow = ov;
      expected_pieces.push_back(p);
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF;
    endfunction

    function bit is_eol(logic [7:0] c);
      return c == CH_LF || c == CH_CR;
    endfunction

    // Predicts the results of one accepted input word.
    function void split_word(logic [7:0] c, logic term);
      bit ov;
      if (term) begin
        push(8'h00, 0, field_opened || after_comma, 1, 0);
        clear_line();
        return;
      end
      if (phase == PH_QSEEN) begin
        if (c == CH_QUOTE) begin
          push(c, 1, 0, 0, 0);
          phase = PH_QUOTED;
          return;
        end
        // The quote closed the field; this byte is handled as one that follows the closing quote.
        phase = PH_AFTERQ;
      end
      case (phase)
        PH_QUOTED: begin
          if (c == CH_QUOTE) phase = PH_QSEEN;
          else push(c, 1, 0, 0, 0);
        end
        PH_AFTERQ: begin
          if (c == CH_COMMA) begin
            push(8'h00, 0, 1, 0, 0);
            phase = PH_START;
            after_comma = 1;
          end else if (is_eol(c)) begin
            phase = PH_DONE;
          end
        end
        PH_START, PH_LEAD, PH_UNQ: begin
          if (is_eol(c)) begin
            held_count = 0;
            spaces_dropped = 0;
            phase = PH_DONE;
          end else if (c == CH_COMMA) begin
            held_count = 0;
            spaces_dropped = 0;
            push(8'h00, 0, 1, 0, 0);
            phase = PH_START;
            field_opened = 1;
            after_comma = 1;
          end else begin
            field_opened = 1;
            after_comma = 0;
            if (phase == PH_START && c == CH_QUOTE) begin
              phase = PH_QUOTED;
            end else if (is_blank(c)) begin
              if (phase == PH_UNQ) begin
                if (held_count < SPACE_BUFFER_DEPTH) begin
                  held_spaces[held_count] = c;
                  held_count++;
                end else begin
                  spaces_dropped = 1;
                end
              end else begin
                phase = PH_LEAD;
              end
            end else begin
              ov = spaces_dropped;
              for (int i = 0; i < held_count; i++) push(held_spaces[i], 1, 0, 0, ov);
              push(c, 1, 0, 0, ov);
              held_count = 0;
              spaces_dropped = 0;
              phase = PH_UNQ;
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_piece(piece_t got);
      piece_t want;
      if (expected_pieces.size() == 0) begin
        $error("unexpected result word: out_byte %0h field_end %0d line_end %0d",
               got.data, got.field_end, got.line_end);
        fail_count++;
        return;
      end
      want = expected_pieces.pop_front();
      if (got.data !== want.data) begin
        $error("out_byte expected %0h actual %0h", want.data, got.data);
        fail_count++;
      end
      if (got.data_valid !== want.data_valid) begin
        $error("byte_valid expected %0d actual %0d", want.data_valid, got.data_valid);
        fail_count++;
      end
      if (got.field_end !== want.field_end) begin
        $error("field_end expected %0d actual %0d", want.field_end, got.field_end);
        fail_count++;
      end
      if (got.line_end !== want.line_end) begin
        $error("line_end expected %0d actual %0d", want.line_end, got.line_end);
        fail_count++;
      end
      if (got.overflow !== want.overflow) begin
        $error("space_overflow expected %0d actual %0d", want.overflow, got.overflow);
        fail_count++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_byte = 8'h00;
  logic       in_terminator = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_out_byte;
  logic       out_byte_valid;
  logic       out_field_end;
  logic       out_line_end;
  logic       out_space_overflow;

  field_split_checker sb = new();
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 45;

  csv_field_splitter_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_char_byte       (in_char_byte),
    .in_terminator      (in_terminator),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_out_byte       (out_out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_field_end      (out_field_end),
    .out_line_end       (out_line_end),
    .out_space_overflow (out_space_overflow)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Both handshakes are observed here, at the rising edge.
  always @(posedge clk) begin : monitor
    piece_t got;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("csv_field_splitter_core regression: fail");
      $finish;
    end
    if (rst_n) begin
      if (in_valid && !in_stall) sb.split_word(in_char_byte, in_terminator);
      if (out_valid && !out_stall) begin
        got.data = out_out_byte;
        got.data_valid = out_byte_valid;
        got.field_end = out_field_end;
        got.line_end = out_line_end;
        got.overflow = out_space_overflow;
        sb.check_piece(got);
      end
    end
  end

  // Called just after a falling edge; returns just after the falling edge
  // that follows the word's acceptance.
  task automatic send_word(input logic [7:0] ch, input logic term);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= ch;
    in_terminator <= term;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_bytes(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_word(bytes[i], 1'b0);
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CH_COMMA || b == CH_LF || b == CH_CR || b == CH_QUOTE ||
               b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 5))
      0: return CH_TAB;
      1: return CH_VT;
      2: return CH_FF;
      default: return CH_SPACE;
    endcase
  endfunction

  task automatic send_blanks(input int n);
    repeat (n) send_word(blank_byte(), 1'b0);
  endtask

  // One random line: mostly well-formed fields with random content, some noise.
  task automatic send_random_line();
    int n_fields;
    int kind;
    int n;
    int r;
    bit open_quote;
    logic [7:0] b;
    open_quote = 0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) send_word(8'($urandom_range(0, 255)), 1'b0);
      send_word(8'($urandom_range(0, 255)), 1'b1);
      return;
    end
    n_fields = $urandom_range(0, 4);
    for (int f = 0; f < n_fields && !open_quote; f++) begin
      if (f > 0) send_word(CH_COMMA, 1'b0);
      kind = $urandom_range(0, 11);
      if (kind >= 1 && kind <= 4) begin
        send_blanks($urandom_range(0, 2));
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          if (i > 0) send_blanks($urandom_range(0, 2));
          b = ($urandom_range(0, 7) == 0) ? CH_QUOTE : plain_byte();
          send_word(b, 1'b0);
        end
        send_blanks($urandom_range(0, 3));
      end else if (kind >= 5 && kind <= 8) begin
        // A blank before the quote turns the quote into plain content.
        if ($urandom_range(0, 7) == 0) send_blanks(1);
        send_word(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 5)) begin
          r = $urandom_range(0, 9);
          if (r <= 1) begin
            send_word(CH_QUOTE, 1'b0);
            send_word(CH_QUOTE, 1'b0);
          end else if (r == 2) begin
            send_word($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
          end else if (r == 3) begin
            send_word(CH_COMMA, 1'b0);
          end else if (r == 4) begin
            send_word(blank_byte(), 1'b0);
          end else begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
            send_word(b, 1'b0);
          end
        end
        if ($urandom_range(0, 9) == 0) begin
          open_quote = 1;
        end else begin
          send_word(CH_QUOTE, 1'b0);
          repeat ($urandom_range(0, 2))
            send_word($urandom_range(0, 1) ? blank_byte() : plain_byte(), 1'b0);
        end
      end else if (kind == 9) begin
        send_word(plain_byte(), 1'b0);
        send_blanks($urandom_range(14, 22));
        send_word(plain_byte(), 1'b0);
        send_blanks($urandom_range(0, 20));
      end else if (kind >= 10) begin
        repeat ($urandom_range(1, 5)) begin
          do b = 8'($urandom_range(0, 255));
          while (b == CH_COMMA || b == CH_LF || b == CH_CR);
          send_word(b, 1'b0);
        end
      end
    end
    if (!open_quote) begin
      r = $urandom_range(0, 9);
      if (r >= 8) begin
        send_word(CH_COMMA, 1'b0);
      end else if (r >= 6) begin
        send_word($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
        repeat ($urandom_range(0, 2)) send_word(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin : main
    logic [7:0] line[$];
    int unsigned stop_at;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Quote after a leading blank, held blanks flushed, extreme byte values,
    // trailing comma.
    line = '{CH_SPACE, CH_QUOTE, 8'h00, CH_SPACE, CH_TAB, 8'hFF, CH_COMMA};
    send_bytes(line);
    // Doubled quote and a line feed inside quotes, junk after the closing quote,
    // a carriage return ending the line and a byte ignored after it.
    line = '{CH_QUOTE, 8'h61, CH_QUOTE, CH_QUOTE, CH_LF, CH_QUOTE, 8'h7A, CH_COMMA,
             CH_CR, 8'h71};
    send_bytes(line);
    // Empty line.
    send_word(8'($urandom_range(0, 255)), 1'b1);
    // Quote left open at the terminator.
    line = '{CH_QUOTE, 8'h62};
    send_bytes(line);
    // Trailing blanks dropped at the end of the line.
    line = '{8'h41, CH_SPACE, CH_VT, CH_CR};
    send_bytes(line);

    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      if (words_sent >= stop_at - RANDOM_WORDS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (words_sent >= stop_at - 2 * RANDOM_WORDS / 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 32;
      end
      send_random_line();
    end
    in_valid <= 1'b0;

    while (sb.expected_pieces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_pieces.size() != 0) begin
      $error("%0d result words never arrived", sb.expected_pieces.size());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("csv_field_splitter_core regression: pass");
    end else begin
      $display("csv_field_splitter_core regression: fail");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/csvfs_pkg.sv
hw/rtl/csvfs_front.sv
hw/rtl/csvfs_cmdq.sv
hw/rtl/csvfs_back.sv
hw/rtl/csv_field_splitter_core.sv
tb/sv/tb.sv
